// ===== hw/rtl/rotary_knob_decoder_macros.svh =====
// assertion helpers shared by the knob decoder modules
`ifndef ROTARY_KNOB_DECODER_MACROS_SVH
`define ROTARY_KNOB_DECODER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define RKD_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define RKD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/rkd_pkg.sv =====
`default_nettype none

package rkd_pkg;

    localparam int TIMER_WIDTH = 20;
    localparam int THRESH_WIDTH = 20;
    localparam int CMP_WIDTH = (TIMER_WIDTH > THRESH_WIDTH) ? TIMER_WIDTH : THRESH_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    localparam int AGE_WIDTH = 16;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};
    localparam int COUNTDOWN_WIDTH = 17;

    localparam int CFG_DATA_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH = 3;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_LOCKOUT     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEPS_PER_DETENT = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK_MIN        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_MIN   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLL_PERIOD      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_HOLDOFF     = 3'd5;

    // event codes
    localparam logic [1:0] ROT_NONE    = 2'd0;
    localparam logic [1:0] ROT_UP      = 2'd1;
    localparam logic [1:0] ROT_DOWN    = 2'd2;
    localparam logic [1:0] PRESS_NONE  = 2'd0;
    localparam logic [1:0] PRESS_CLICK = 2'd1;
    localparam logic [1:0] PRESS_LONG  = 2'd2;

    // direction per {previous a, previous b, a, b}
    localparam logic signed [1:0] DIR_TABLE [0:15] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [15:0] step_lockout;
        logic [2:0]  steps_per_detent;
        logic [19:0] click_min;
        logic [19:0] long_press_min;
        logic [15:0] poll_period;
        logic [15:0] edge_holdoff;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/rkd_in_if.sv =====
`default_nettype none

interface rkd_in_if;
    logic valid;
    logic ready;
    logic line_a;
    logic line_b;
    logic switch_level;

    modport source (output valid, output line_a, output line_b, output switch_level,
                    input ready);
    modport sink (input valid, input line_a, input line_b, input switch_level,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rkd_out_if.sv =====
`default_nettype none

interface rkd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] rotation;
    logic [1:0] press;

    modport source (output valid, output rotation, output press, input ready);
    modport sink (input valid, input rotation, input press, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rkd_quad.sv =====
`default_nettype none
`include "rotary_knob_decoder_macros.svh"

module rkd_quad (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_line_a,
    input  wire logic           i_line_b,
    input  wire rkd_pkg::t_cfg  i_cfg,
    output logic [1:0]          o_rotation
);

    logic [3:0]                       r_hist, n_hist;
    logic [rkd_pkg::AGE_WIDTH-1:0]    r_age, n_age, age_inc;
    logic signed [3:0]                r_sum, n_sum;
    logic [3:0]                       idx;
    logic signed [1:0]                dir;
    logic signed [4:0]                sum_ext, lim;
    logic                             step_nz;

    always_comb begin
        age_inc = (r_age == rkd_pkg::AGE_MAX) ? r_age : r_age + 16'd1;
        idx     = {r_hist[1:0], i_line_a, i_line_b};
        dir     = rkd_pkg::DIR_TABLE[idx];
        lim     = signed'({2'b00, i_cfg.steps_per_detent});
        sum_ext = signed'({r_sum[3], r_sum}) + signed'({{3{dir[1]}}, dir});
        n_hist  = r_hist;
        n_age   = age_inc;
        n_sum   = r_sum;
        step_nz = 1'b0;
        o_rotation = rkd_pkg::ROT_NONE;
        if (age_inc >= i_cfg.step_lockout) begin
            n_hist = idx;
            if (dir != 2'sd0) begin
                step_nz = 1'b1;
                n_age   = '0;
                n_sum   = sum_ext[3:0];
                if (sum_ext >= lim) begin
                    o_rotation = rkd_pkg::ROT_UP;
                    n_sum      = '0;
                end else if (sum_ext <= -lim) begin
                    o_rotation = rkd_pkg::ROT_DOWN;
                    n_sum      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= 4'd3;
            r_age  <= rkd_pkg::AGE_MAX;
            r_sum  <= '0;
        end else if (i_adv) begin
            r_hist <= n_hist;
            r_age  <= n_age;
            r_sum  <= n_sum;
        end
    end

    `RKD_ASSERT_NEXT(a_step_restarts_lockout, i_clk, i_rst_n, i_adv && step_nz,
                     r_age == '0, "accepted step did not restart lockout")
    `RKD_ASSERT_NOW(a_sum_in_range, i_clk, i_rst_n, 1'b1,
                    r_sum != 4'sb1000, "step sum out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/rkd_switch.sv =====
`default_nettype none
`include "rotary_knob_decoder_macros.svh"

module rkd_switch (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_switch_level,
    input  wire rkd_pkg::t_cfg  i_cfg,
    output logic [1:0]          o_press
);

    logic                                  r_prior, n_prior;
    logic [rkd_pkg::TIMER_WIDTH-1:0]       r_timer, n_timer, timer_inc;
    logic [rkd_pkg::COUNTDOWN_WIDTH-1:0]   r_cd, n_cd;
    logic [rkd_pkg::CMP_WIDTH-1:0]         timer_cmp, long_cmp, click_cmp;
    logic [15:0]                           period;
    logic                                  sw_edge;

    always_comb begin
        timer_inc = (r_timer == rkd_pkg::TIMER_MAX) ? r_timer
                                                     : r_timer + rkd_pkg::TIMER_WIDTH'(1);
        timer_cmp = rkd_pkg::CMP_WIDTH'(timer_inc);
        long_cmp  = rkd_pkg::CMP_WIDTH'(i_cfg.long_press_min);
        click_cmp = rkd_pkg::CMP_WIDTH'(i_cfg.click_min);
        period    = (i_cfg.poll_period == 16'd0) ? 16'd1 : i_cfg.poll_period;
        n_prior   = r_prior;
        n_timer   = timer_inc;
        n_cd      = r_cd;
        sw_edge   = 1'b0;
        o_press   = rkd_pkg::PRESS_NONE;
        if (r_cd != '0) begin
            n_cd = r_cd - 17'd1;
        end else begin
            if (r_prior && !i_switch_level) begin
                n_timer = '0;
                sw_edge = 1'b1;
            end else if (!r_prior && i_switch_level) begin
                if (timer_cmp >= long_cmp) begin
                    o_press = rkd_pkg::PRESS_LONG;
                end else if (timer_cmp >= click_cmp) begin
                    o_press = rkd_pkg::PRESS_CLICK;
                end
                sw_edge = 1'b1;
            end
            n_prior = i_switch_level;
            n_cd    = {1'b0, period - 16'd1}
                      + (sw_edge ? {1'b0, i_cfg.edge_holdoff} : 17'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= 1'b1;
            r_timer <= '0;
            r_cd    <= '0;
        end else if (i_adv) begin
            r_prior <= n_prior;
            r_timer <= n_timer;
            r_cd    <= n_cd;
        end
    end

    `RKD_ASSERT_NEXT(a_no_poll_in_countdown, i_clk, i_rst_n, i_adv && (r_cd != '0),
                     $stable(r_prior), "switch sampled during poll countdown")
    `RKD_ASSERT_NOW(a_press_only_on_release, i_clk, i_rst_n, o_press != rkd_pkg::PRESS_NONE,
                    !r_prior && i_switch_level && (r_cd == '0),
                    "press event without a polled release")

endmodule

`default_nettype wire

// ===== hw/rtl/rotary_knob_decoder.sv =====
// an input transaction reaches its result through the input register and then the result register
// throughput: one transaction per cycle while the output side takes each result, set by the single-pass tick logic
// the input register drains into the result register whenever that is empty or being taken
// reset (synchronous, active low) restores register defaults, lines idle high, switch released
// after reset the first accepted sample polls the switch at once
`default_nettype none
`include "rotary_knob_decoder_macros.svh"

module rotary_knob_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    rkd_in_if.sink                                   i_in_ch,
    rkd_out_if.source                                o_out_ch,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [rkd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [rkd_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata
);

    // configuration registers
    rkd_pkg::t_cfg r_cfg;

    // input register: one sample per transaction
    logic r_in_valid;
    logic r_in_a;
    logic r_in_b;
    logic r_in_sw;

    // result register
    logic       r_out_valid;
    logic [1:0] r_rotation;
    logic [1:0] r_press;

    logic       adv;
    logic [1:0] rotation;
    logic [1:0] press;

    // a held sample moves on when the result slot is free or emptying this cycle
    assign adv             = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready   = !r_in_valid || adv;

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.rotation = r_rotation;
    assign o_out_ch.press    = r_press;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_lockout     <= 16'd1000;
            r_cfg.steps_per_detent <= 3'd4;
            r_cfg.click_min        <= 20'd30000;
            r_cfg.long_press_min   <= 20'd800000;
            r_cfg.poll_period      <= 16'd20000;
            r_cfg.edge_holdoff     <= 16'd30000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rkd_pkg::REG_STEP_LOCKOUT:     r_cfg.step_lockout     <= i_cfg_wdata[15:0];
                rkd_pkg::REG_STEPS_PER_DETENT: r_cfg.steps_per_detent <= i_cfg_wdata[2:0];
                rkd_pkg::REG_CLICK_MIN:        r_cfg.click_min        <= i_cfg_wdata[19:0];
                rkd_pkg::REG_LONG_PRESS_MIN:   r_cfg.long_press_min   <= i_cfg_wdata[19:0];
                rkd_pkg::REG_POLL_PERIOD:      r_cfg.poll_period      <= i_cfg_wdata[15:0];
                rkd_pkg::REG_EDGE_HOLDOFF:     r_cfg.edge_holdoff     <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // input register, payload kept without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_a  <= i_in_ch.line_a;
            r_in_b  <= i_in_ch.line_b;
            r_in_sw <= i_in_ch.switch_level;
        end
    end

    // quadrature side: lockout, direction lookup, step sum
    rkd_quad u_quad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_line_a   (r_in_a),
        .i_line_b   (r_in_b),
        .i_cfg      (r_cfg),
        .o_rotation (rotation)
    );

    // switch side: poll countdown, edge detection, press timing
    rkd_switch u_switch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_switch_level (r_in_sw),
        .i_cfg          (r_cfg),
        .o_press        (press)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rotation <= rotation;
            r_press    <= press;
        end
    end

    `RKD_ASSERT_NEXT(a_adv_fills_result, i_clk, i_rst_n, adv, r_out_valid,
                     "tick result lost on its way to the result register")

endmodule

`default_nettype wire
